FILE: sv/ffpa_pkg.sv
// Shared types and codes for the first-fit partition allocator.
// No dependencies.
`default_nettype none
package ffpa_pkg;
  localparam int         MEM_UNITS  = 128;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_NO_JOB  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;
  localparam logic       ACT_ALLOC  = 1'b0;
  localparam logic       ACT_FREE   = 1'b1;
endpackage
`default_nettype wire

FILE: sv/ffpa_cell.sv
// One table cell: holds an entry and shifts to or from its neighbors.
// Depends on nothing; used for both the free and the job table.
`default_nettype none
module ffpa_cell #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         rst_used,
  input  wire logic [W-1:0] rst_data,
  input  wire logic         ld,
  input  wire logic [W-1:0] ld_data,
  input  wire logic         ld_used,
  output logic [W-1:0]      data,
  output logic              used
);
  always_ff @(posedge clk) begin
    if (rst) begin
      data <= rst_data;
      used <= rst_used;
    end else if (ld) begin
      data <= ld_data;
      used <= ld_used;
    end
  end
endmodule
`default_nettype wire

FILE: sv/first_fit_partition_allocator_top.sv
// Top level: chain of free-table cells and job-table cells, plus a sequencer.
// Depends on ffpa_pkg and ffpa_cell.
//
// channel | beat fields                       | handshake
// in      | action, job_id, req_size          | in_valid / in_stall
// out     | status, start_addr, length        | out_valid / out_stall
//
// Allocate scans the free chain to the first fit, then counts the job chain.
// Release searches the job chain, scans the free chain for neighbors and, with
// none, scans it again for the insertion point; one cell a cycle per scan.
// The chains shift all their cells at once. One item at a time; the next is
// accepted once the result leaves the output register. Reset restores one
// free span.
`default_nettype none
module first_fit_partition_allocator_top
  import ffpa_pkg::*;
#(
  parameter int FREE_ENTRIES = 16,
  parameter int JOB_ENTRIES  = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       action,
  input  wire logic [7:0] job_id,
  input  wire logic [7:0] req_size,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      status,
  output logic [6:0]      start_addr,
  output logic [7:0]      length
);
  localparam int FW = 15;
  localparam int JW = 23;
  localparam int FI = $clog2(FREE_ENTRIES + 1);
  localparam int JI = $clog2(JOB_ENTRIES + 1);
  localparam logic [7:0] MEM_LEN = 8'(MEM_UNITS);

  localparam logic [2:0] S_IDLE = 3'd0, S_FSCAN = 3'd1, S_JSCAN = 3'd2,
                         S_MSCAN = 3'd3, S_ISCAN = 3'd4, S_DONE = 3'd5;

  logic [2:0] state;
  logic       act;
  logic [7:0] id, sz;
  logic [FI-1:0] fi;
  logic [JI-1:0] ji;
  logic [6:0] b;
  logic [7:0] l;
  logic       has_lo, has_hi;
  logic [FI-1:0] lo, hi;

  logic [FW-1:0] fdat [FREE_ENTRIES];
  logic          fused [FREE_ENTRIES];
  logic [FW-1:0] fld_d [FREE_ENTRIES];
  logic          fld_u [FREE_ENTRIES];
  logic          fld [FREE_ENTRIES];
  logic [JW-1:0] jdat [JOB_ENTRIES];
  logic          jused [JOB_ENTRIES];
  logic [JW-1:0] jld_d [JOB_ENTRIES];
  logic          jld_u [JOB_ENTRIES];
  logic          jld [JOB_ENTRIES];

  // Operation selected for the chain update.
  localparam logic [2:0] F_NONE = 3'd0, F_ALLOC = 3'd1, F_BOTH = 3'd2,
                         F_LO = 3'd3, F_HI = 3'd4, F_INS = 3'd5;
  logic [2:0] fop;
  logic       jpush, jpop;
  logic [JI-1:0] jk;

  genvar g;
  generate
    for (g = 0; g < FREE_ENTRIES; g++) begin : g_f
      ffpa_cell #(.W(FW)) u_c (.clk, .rst,
        .rst_used(g == 0), .rst_data(g == 0 ? {7'd0, MEM_LEN} : '0),
        .ld(fld[g]), .ld_data(fld_d[g]), .ld_used(fld_u[g]),
        .data(fdat[g]), .used(fused[g]));
    end
    for (g = 0; g < JOB_ENTRIES; g++) begin : g_j
      ffpa_cell #(.W(JW)) u_c (.clk, .rst, .rst_used(1'b0), .rst_data('0),
        .ld(jld[g]), .ld_data(jld_d[g]), .ld_used(jld_u[g]),
        .data(jdat[g]), .used(jused[g]));
    end
  endgenerate

  logic [FI-1:0] fk;
  logic          fk_ok, jk_ok;
  logic [6:0]    fs;
  logic [7:0]    fl;
  logic [FW-1:0] cur_f;
  logic [JW-1:0] cur_j;
  assign fk_ok = (fi < FI'(FREE_ENTRIES)) && fused[fi[$clog2(FREE_ENTRIES)-1:0]];
  assign cur_f = fk_ok ? fdat[fi[$clog2(FREE_ENTRIES)-1:0]] : '0;
  assign fs = cur_f[FW-1:8];
  assign fl = cur_f[7:0];
  assign jk_ok = (ji < JI'(JOB_ENTRIES)) && jused[ji[$clog2(JOB_ENTRIES)-1:0]];
  assign cur_j = jk_ok ? jdat[ji[$clog2(JOB_ENTRIES)-1:0]] : '0;
  assign fk = fi;

  // Chain update logic.
  always_comb begin
    for (int i = 0; i < FREE_ENTRIES; i++) begin
      fld[i] = 1'b0; fld_d[i] = fdat[i]; fld_u[i] = fused[i];
      case (fop)
        F_ALLOC: begin
          if (FI'(i) == fk && fl != sz) begin
            fld[i] = 1'b1; fld_d[i] = {7'(fs + sz[6:0]), 8'(fl - sz)};
          end else if (FI'(i) >= fk && fl == sz) begin
            fld[i] = 1'b1;
            fld_d[i] = (i + 1 < FREE_ENTRIES) ? fdat[(i + 1) % FREE_ENTRIES] : '0;
            fld_u[i] = (i + 1 < FREE_ENTRIES) ? fused[(i + 1) % FREE_ENTRIES] : 1'b0;
            if (!fld_u[i]) fld_d[i] = '0;
          end
        end
        F_BOTH: begin
          if (FI'(i) == lo) begin
            fld[i] = 1'b1;
            fld_d[i] = {fdat[i][FW-1:8],
                        8'(fdat[i][7:0] + l + fdat[hi[$clog2(FREE_ENTRIES)-1:0]][7:0])};
          end else if (FI'(i) >= hi) begin
            fld[i] = 1'b1;
            fld_d[i] = (i + 1 < FREE_ENTRIES) ? fdat[(i + 1) % FREE_ENTRIES] : '0;
            fld_u[i] = (i + 1 < FREE_ENTRIES) ? fused[(i + 1) % FREE_ENTRIES] : 1'b0;
            if (!fld_u[i]) fld_d[i] = '0;
          end
        end
        F_LO: if (FI'(i) == lo) begin
          fld[i] = 1'b1; fld_d[i] = {fdat[i][FW-1:8], 8'(fdat[i][7:0] + l)};
        end
        F_HI: if (FI'(i) == hi) begin
          fld[i] = 1'b1;
          fld_d[i] = {7'(fdat[i][FW-1:8] - l[6:0]), 8'(fdat[i][7:0] + l)};
        end
        F_INS: begin
          // fk is insertion point
          if (FI'(i) == fk) begin
            fld[i] = 1'b1; fld_d[i] = {b, l}; fld_u[i] = 1'b1;
          end else if (FI'(i) > fk && i > 0) begin
            fld[i] = 1'b1; fld_d[i] = fdat[(i + FREE_ENTRIES - 1) % FREE_ENTRIES];
            fld_u[i] = fused[(i + FREE_ENTRIES - 1) % FREE_ENTRIES];
          end
        end
        default: ;
      endcase
    end
    for (int i = 0; i < JOB_ENTRIES; i++) begin
      jld[i] = 1'b0; jld_d[i] = jdat[i]; jld_u[i] = jused[i];
      if (jpush) begin
        jld[i] = 1'b1;
        if (i == 0) begin
          jld_d[i] = {id, fs, sz}; jld_u[i] = 1'b1;
        end else begin
          jld_d[i] = jdat[(i + JOB_ENTRIES - 1) % JOB_ENTRIES];
          jld_u[i] = jused[(i + JOB_ENTRIES - 1) % JOB_ENTRIES];
        end
      end else if (jpop && JI'(i) >= jk) begin
        jld[i] = 1'b1;
        jld_d[i] = (i + 1 < JOB_ENTRIES) ? jdat[(i + 1) % JOB_ENTRIES] : jdat[i];
        jld_u[i] = (i + 1 < JOB_ENTRIES) ? jused[(i + 1) % JOB_ENTRIES] : 1'b0;
      end
    end
  end

  logic [7:0] sum_lo;
  assign sum_lo = 8'(fs + fl);
  logic [8:0] b_hi;
  assign b_hi = 9'(b) + 9'(l);

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0;
      fop <= F_NONE; jpush <= 1'b0; jpop <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && !in_stall) begin
          act <= action; id <= job_id; sz <= req_size;
          fi <= '0; ji <= '0; has_lo <= 1'b0; has_hi <= 1'b0;
          state <= (action == ACT_ALLOC) ? S_FSCAN : S_JSCAN;
        end
        S_FSCAN: begin
          if (sz == 8'd0 || !fk_ok) begin
            status <= ST_NO_FIT; start_addr <= '0; length <= '0; state <= S_DONE;
          end else if (fl >= sz) begin
            state <= S_JSCAN;
          end else fi <= fi + 1'b1;
        end
        S_JSCAN: begin
          if (act == ACT_ALLOC) begin
            if (jk_ok) ji <= ji + 1'b1;
            else if (ji >= JI'(JOB_ENTRIES)) begin
              status <= ST_FULL; start_addr <= '0; length <= '0; state <= S_DONE;
            end else begin
              fop <= F_ALLOC; jpush <= 1'b1;
              status <= ST_OK; start_addr <= fs; length <= sz; state <= S_DONE;
            end
          end else if (!jk_ok) begin
            status <= ST_NO_JOB; start_addr <= '0; length <= '0; state <= S_DONE;
          end else if (cur_j[JW-1:15] == id) begin
            b <= cur_j[14:8]; l <= cur_j[7:0]; jk <= ji; state <= S_MSCAN;
          end else ji <= ji + 1'b1;
        end
        S_MSCAN: begin
          if (fk_ok) begin
            if (!has_lo && {1'b0, sum_lo} == 9'(b)) begin has_lo <= 1'b1; lo <= fi; end
            if (!has_hi && 9'(fs) == b_hi) begin has_hi <= 1'b1; hi <= fi; end
            fi <= fi + 1'b1;
          end else if (has_lo || has_hi) begin
            fop <= (has_lo && has_hi) ? F_BOTH : (has_lo ? F_LO : F_HI);
            jpop <= 1'b1;
            status <= ST_OK; start_addr <= b; length <= l; state <= S_DONE;
          end else if (fi >= FI'(FREE_ENTRIES)) begin
            status <= ST_FULL; start_addr <= '0; length <= '0; state <= S_DONE;
          end else begin
            fi <= '0; state <= S_ISCAN;
          end
        end
        S_ISCAN: begin
          if (fk_ok && fs <= b) fi <= fi + 1'b1;
          else begin
            fop <= F_INS; jpop <= 1'b1;
            status <= ST_OK; start_addr <= b; length <= l; state <= S_DONE;
          end
        end
        S_DONE: begin
          out_valid <= 1'b1; state <= S_IDLE;
          fop <= F_NONE; jpush <= 1'b0; jpop <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall) else $error("input taken while result waits");
  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> length == 8'd0 && start_addr == 7'd0)
    else $error("failure carries nonzero span");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall) else $error("accept while busy");
  a_head: assert property (@(posedge clk) disable iff (rst)
    !fused[0] |-> !fused[FREE_ENTRIES-1]) else $error("free chain not packed");
endmodule
`default_nettype wire

FILE: tb/ffpa_scoreboard.sv
// Scoreboard for the first-fit partition allocator: mirrors the free and job
// tables and checks each output beat. Depends on ffpa_pkg.
`timescale 1ns / 100ps
class ffpa_scoreboard;
  typedef struct packed {
    logic [1:0] status;
    logic [6:0] start_addr;
    logic [7:0] length;
  } grant_t;

  int unsigned fr_start[16];
  int unsigned fr_len[16];
  int unsigned nfree;
  logic [7:0]  jb_key[16];
  int unsigned jb_base[16];
  int unsigned jb_len[16];
  int unsigned njob;
  grant_t      pending[$];
  int unsigned errors;

  function new();
    nfree = 1;
    fr_start[0] = 0;
    fr_len[0] = 128;
    njob = 0;
    errors = 0;
  endfunction

  function void drop_free(int unsigned k);
    for (int unsigned i = k; i + 1 < nfree; i++) begin
      fr_start[i] = fr_start[i + 1];
      fr_len[i] = fr_len[i + 1];
    end
    nfree--;
  endfunction

  function grant_t do_alloc(logic [7:0] id, int unsigned sz);
    grant_t g;
    int unsigned k;
    g = '{ffpa_pkg::ST_NO_FIT, 7'd0, 8'd0};
    if (sz == 0) return g;
    for (k = 0; k < nfree; k++) if (fr_len[k] >= sz) break;
    if (k == nfree) return g;
    if (njob >= 16) begin
      g.status = ffpa_pkg::ST_FULL;
      return g;
    end
    for (int unsigned i = njob; i > 0; i--) begin
      jb_key[i] = jb_key[i - 1];
      jb_base[i] = jb_base[i - 1];
      jb_len[i] = jb_len[i - 1];
    end
    jb_key[0] = id;
    jb_base[0] = fr_start[k];
    jb_len[0] = sz;
    njob++;
    g = '{ffpa_pkg::ST_OK, fr_start[k][6:0], sz[7:0]};
    fr_start[k] += sz;
    fr_len[k] -= sz;
    if (fr_len[k] == 0) drop_free(k);
    return g;
  endfunction

  function grant_t do_release(logic [7:0] id);
    grant_t g;
    int unsigned j, k, lo, hi, b, l;
    bit has_lo, has_hi;
    g = '{ffpa_pkg::ST_NO_JOB, 7'd0, 8'd0};
    has_lo = 0;
    has_hi = 0;
    lo = 0;
    hi = 0;
    for (j = 0; j < njob; j++) if (jb_key[j] == id) break;
    if (j == njob) return g;
    b = jb_base[j];
    l = jb_len[j];
    for (k = 0; k < nfree; k++) begin
      if (!has_lo && fr_start[k] + fr_len[k] == b) begin
        lo = k;
        has_lo = 1;
      end
      if (!has_hi && fr_start[k] == b + l) begin
        hi = k;
        has_hi = 1;
      end
    end
    if (has_lo && has_hi) begin
      fr_len[lo] += l + fr_len[hi];
      drop_free(hi);
    end else if (has_lo) begin
      fr_len[lo] += l;
    end else if (has_hi) begin
      fr_start[hi] -= l;
      fr_len[hi] += l;
    end else begin
      if (nfree >= 16) begin
        g.status = ffpa_pkg::ST_FULL;
        return g;
      end
      k = nfree;
      while (k > 0 && fr_start[k - 1] > b) begin
        fr_start[k] = fr_start[k - 1];
        fr_len[k] = fr_len[k - 1];
        k--;
      end
      fr_start[k] = b;
      fr_len[k] = l;
      nfree++;
    end
    for (int unsigned i = j; i + 1 < njob; i++) begin
      jb_key[i] = jb_key[i + 1];
      jb_base[i] = jb_base[i + 1];
      jb_len[i] = jb_len[i + 1];
    end
    njob--;
    return '{ffpa_pkg::ST_OK, b[6:0], l[7:0]};
  endfunction

  function void note_request(logic act, logic [7:0] id, logic [7:0] sz);
    if (act == ffpa_pkg::ACT_ALLOC) pending.push_back(do_alloc(id, sz));
    else pending.push_back(do_release(id));
  endfunction

  function void check_grant(logic [1:0] st, logic [6:0] sa, logic [7:0] ln);
    grant_t e;
    if (pending.size() == 0) begin
      $error("unexpected output beat status=%0d start_addr=%0d length=%0d", st, sa, ln);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (st !== e.status) begin
      $error("status expected %0d actual %0d", e.status, st);
      errors++;
    end
    if (sa !== e.start_addr) begin
      $error("start_addr expected %0d actual %0d", e.start_addr, sa);
      errors++;
    end
    if (ln !== e.length) begin
      $error("length expected %0d actual %0d", e.length, ln);
      errors++;
    end
  endfunction
endclass

FILE: tb/tb.sv
// Testbench top for first_fit_partition_allocator_top: directed and random
// allocate/release beats with random gaps and output stalls.
// Depends on ffpa_pkg, ffpa_scoreboard and the block RTL.
`timescale 1ns / 100ps
module tb;
  import ffpa_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic action = ACT_ALLOC;
  logic [7:0] job_id = 8'd1;
  logic [7:0] req_size = 8'd1;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] status;
  logic [6:0] start_addr;
  logic [7:0] length;
  int unsigned cycles = 0;
  bit stall_mode = 0;
  ffpa_scoreboard board = new();

  first_fit_partition_allocator_top uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .job_id(job_id), .req_size(req_size),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .start_addr(start_addr), .length(length)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("[first_fit_partition_allocator_top] ERROR");
      $finish;
    end
    if (!rst && out_valid && !out_stall) board.check_grant(status, start_addr, length);
  end

  always @(negedge clk) begin
    if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 2) != 0;
    out_stall <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b0;
  end

  int unsigned burst_left = 0;

  task automatic send_beat(logic act, logic [7:0] id, logic [7:0] sz);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        in_valid <= 0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1;
    action <= act;
    job_id <= id;
    req_size <= sz;
    do @(posedge clk); while (in_stall);
    board.note_request(act, id, sz);
    @(negedge clk);
  endtask

  logic [7:0] live_ids[$];
  logic [7:0] id;
  int unsigned r;

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    send_beat(ACT_ALLOC, 8'd5, 8'd0);
    send_beat(ACT_ALLOC, 8'd5, 8'd129);
    send_beat(ACT_ALLOC, 8'd5, 8'd255);
    send_beat(ACT_FREE, 8'd9, 8'd0);
    send_beat(ACT_ALLOC, 8'd0, 8'd128);
    send_beat(ACT_ALLOC, 8'd1, 8'd1);
    send_beat(ACT_FREE, 8'd0, 8'd0);
    for (int i = 0; i < 16; i++) send_beat(ACT_ALLOC, 8'd7, 8'd8);
    send_beat(ACT_FREE, 8'd7, 8'hff);
    for (int i = 0; i < 16; i++) send_beat(ACT_FREE, 8'd7, 8'd0);
    for (int i = 0; i < 16; i++) send_beat(ACT_ALLOC, 8'(i + 240), 8'd2);
    send_beat(ACT_ALLOC, 8'd255, 8'd1);
    for (int i = 0; i < 16; i += 2) send_beat(ACT_FREE, 8'(i + 240), 8'd0);
    send_beat(ACT_FREE, 8'd243, 8'd0);
    for (int i = 0; i < 16; i++) send_beat(ACT_FREE, 8'(i + 240), 8'd0);
    for (int n = 0; n < 1868; n++) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        id = (r < 5) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 15));
        live_ids.push_back(id);
        send_beat(ACT_ALLOC, id,
                  (r < 3) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 20)));
      end else if (r < 92 && live_ids.size() > 0) begin
        r = $urandom_range(0, live_ids.size() - 1);
        id = live_ids[r];
        live_ids.delete(r);
        send_beat(ACT_FREE, id, 8'($urandom_range(0, 255)));
      end else begin
        send_beat(ACT_FREE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
    end
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.errors == 0) $display("[first_fit_partition_allocator_top] OK");
    else $display("[first_fit_partition_allocator_top] ERROR");
    $finish;
  end
endmodule
